FILE: hdl/vppu_pkg.sv
// Package for the video processor register port: transfer types, op and
// register codes, and the video address fold. No dependencies.
package vppu_pkg;

  localparam int unsigned VIDEO_AW  = 14;
  localparam int unsigned SPRITE_AW = 8;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [1:0] RD_DIRECT  = 2'd0;
  localparam logic [1:0] RD_SPRITE  = 2'd1;
  localparam logic [1:0] RD_BUFFER  = 2'd2;
  localparam logic [1:0] RD_PALETTE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_index;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] vram_address;
    logic [14:0] temp_address;
    logic [2:0]  fine_x_scroll;
    logic [7:0]  control_byte;
    logic [7:0]  mask_byte;
  } out_t;

  function automatic logic [VIDEO_AW-1:0] fold_address(input logic [15:0] addr);
    logic [VIDEO_AW-1:0] a;
    a = addr[VIDEO_AW-1:0];
    if (a >= 14'h2000 && a <= 14'h3EFF) begin
      a[12] = 1'b0;
    end else if (a >= 14'h3F00) begin
      a[7:5] = 3'b000;
    end
    if (a == 14'h3F10 || a == 14'h3F14 || a == 14'h3F18 || a == 14'h3F1C) begin
      a[7:4] = 4'h0;
    end
    return a;
  endfunction

endpackage

FILE: hdl/video_ppu_register_port_top.sv
// Register port of a tile video processor with its video and sprite memories.
// Depends on vppu_pkg for transfer types, codes and the address fold.
//
// Path: each result is registered in stage one, then in the output register.
// Throughput: one transfer per cycle while in_stall is low; each item gives
// two video reads and one sprite read. Reset: control state clears at once;
// a clearing pass then zeroes both memories, during which in_stall stays high.
module video_ppu_register_port_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vppu_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output vppu_pkg::out_t out_item
);

  logic [7:0] vid_mem [0:(1 << vppu_pkg::VIDEO_AW)-1];
  logic [7:0] spr_mem [0:(1 << vppu_pkg::SPRITE_AW)-1];

  logic                        clearing_r;
  logic [vppu_pkg::VIDEO_AW-1:0] clr_cnt_r;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [14:0] tmp_addr_r, tmp_addr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic        toggle_r, toggle_nxt;
  logic [7:0]  spr_ptr_r, spr_ptr_nxt;
  logic [7:0]  rbuf_r;

  logic        s1_v_r;
  logic [1:0]  s1_kind_r, kind_nxt;
  vppu_pkg::out_t s1_item_r, s1_item_nxt;
  logic        out_v_r;
  vppu_pkg::out_t out_item_r;
  vppu_pkg::out_t s1_out;

  logic [7:0]  vid_rd_a_r, vid_rd_b_r, spr_rd_r;
  logic [7:0]  direct_nxt;
  logic [15:0] step_addr;
  logic [vppu_pkg::VIDEO_AW-1:0] addr_a, addr_b;
  logic        vid_we, spr_we;
  logic [vppu_pkg::VIDEO_AW-1:0] vid_waddr;
  logic [vppu_pkg::SPRITE_AW-1:0] spr_waddr;
  logic [7:0]  vid_wdata, spr_wdata;
  logic        do_vid_wr, do_spr_wr;
  logic        out_free, acc, s1_move;
  logic [7:0]  s1_read_data;

  assign out_free  = !out_v_r || !out_stall;
  assign s1_move   = s1_v_r && out_free;
  assign in_stall  = clearing_r || (s1_v_r && !out_free);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  assign step_addr = cur_addr_r + (ctrl_r[2] ? 16'd32 : 16'd1);
  assign addr_a    = vppu_pkg::fold_address(cur_addr_r);
  assign addr_b    = vppu_pkg::fold_address(cur_addr_r & 16'hEFFF);

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    cur_addr_nxt = cur_addr_r;
    tmp_addr_nxt = tmp_addr_r;
    fine_x_nxt   = fine_x_r;
    toggle_nxt   = toggle_r;
    spr_ptr_nxt  = spr_ptr_r;
    kind_nxt     = vppu_pkg::RD_DIRECT;
    direct_nxt   = 8'h00;
    do_vid_wr    = 1'b0;
    do_spr_wr    = 1'b0;
    case (in_item.op)
      vppu_pkg::OP_READ: begin
        case (in_item.reg_index)
          vppu_pkg::REG_STATUS: begin
            direct_nxt = status_r;
            toggle_nxt = 1'b0;
            status_nxt = status_r & 8'h7F;
          end
          vppu_pkg::REG_OAM_DATA: begin
            kind_nxt = vppu_pkg::RD_SPRITE;
          end
          vppu_pkg::REG_DATA: begin
            kind_nxt = (cur_addr_r[13:0] <= 14'h3EFF) ? vppu_pkg::RD_BUFFER
                                                      : vppu_pkg::RD_PALETTE;
            cur_addr_nxt = step_addr;
          end
          default: begin
          end
        endcase
      end
      vppu_pkg::OP_WRITE: begin
        case (in_item.reg_index)
          vppu_pkg::REG_CTRL: begin
            ctrl_nxt            = in_item.data_in;
            tmp_addr_nxt[11:10] = in_item.data_in[1:0];
          end
          vppu_pkg::REG_MASK: begin
            mask_nxt = in_item.data_in;
          end
          vppu_pkg::REG_OAM_ADDR: begin
            spr_ptr_nxt = in_item.data_in;
          end
          vppu_pkg::REG_OAM_DATA: begin
            do_spr_wr   = 1'b1;
            spr_ptr_nxt = spr_ptr_r + 8'd1;
          end
          vppu_pkg::REG_SCROLL: begin
            if (!toggle_r) begin
              fine_x_nxt        = in_item.data_in[2:0];
              tmp_addr_nxt[4:0] = in_item.data_in[7:3];
            end else begin
              tmp_addr_nxt[9:5]   = in_item.data_in[7:3];
              tmp_addr_nxt[14:12] = in_item.data_in[2:0];
            end
            toggle_nxt = !toggle_r;
          end
          vppu_pkg::REG_ADDR: begin
            if (!toggle_r) begin
              cur_addr_nxt = {in_item.data_in, 8'h00};
              tmp_addr_nxt = {1'b0, in_item.data_in[5:0], tmp_addr_r[7:0]};
            end else begin
              tmp_addr_nxt = {tmp_addr_r[14:8], in_item.data_in};
              cur_addr_nxt = {1'b0, tmp_addr_r[14:8], in_item.data_in};
            end
            toggle_nxt = !toggle_r;
          end
          vppu_pkg::REG_DATA: begin
            do_vid_wr    = 1'b1;
            cur_addr_nxt = step_addr;
          end
          default: begin
          end
        endcase
      end
      vppu_pkg::OP_STATUS: begin
        status_nxt = in_item.data_in;
      end
      default: begin
      end
    endcase
    s1_item_nxt.read_data     = direct_nxt;
    s1_item_nxt.vram_address  = cur_addr_nxt;
    s1_item_nxt.temp_address  = tmp_addr_nxt;
    s1_item_nxt.fine_x_scroll = fine_x_nxt;
    s1_item_nxt.control_byte  = ctrl_nxt;
    s1_item_nxt.mask_byte     = mask_nxt;
  end

  always_comb begin
    vid_we    = clearing_r || (acc && do_vid_wr);
    vid_waddr = clearing_r ? clr_cnt_r : addr_a;
    vid_wdata = clearing_r ? 8'h00 : in_item.data_in;
    spr_we    = clearing_r || (acc && do_spr_wr);
    spr_waddr = clearing_r ? clr_cnt_r[vppu_pkg::SPRITE_AW-1:0] : spr_ptr_r;
    spr_wdata = clearing_r ? 8'h00 : in_item.data_in;
  end

  always_ff @(posedge clk) begin
    if (vid_we) begin
      vid_mem[vid_waddr] <= vid_wdata;
    end
    if (acc) begin
      vid_rd_a_r <= vid_mem[addr_a];
      vid_rd_b_r <= vid_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (spr_we) begin
      spr_mem[spr_waddr] <= spr_wdata;
    end
    if (acc) begin
      spr_rd_r <= spr_mem[spr_ptr_r];
    end
  end

  always_comb begin
    case (s1_kind_r)
      vppu_pkg::RD_SPRITE:  s1_read_data = spr_rd_r;
      vppu_pkg::RD_BUFFER:  s1_read_data = rbuf_r;
      vppu_pkg::RD_PALETTE: s1_read_data = vid_rd_a_r;
      default:              s1_read_data = s1_item_r.read_data;
    endcase
    s1_out           = s1_item_r;
    s1_out.read_data = s1_read_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      ctrl_r     <= 8'h00;
      mask_r     <= 8'h00;
      status_r   <= 8'h00;
      cur_addr_r <= 16'h0000;
      tmp_addr_r <= 15'h0000;
      fine_x_r   <= 3'h0;
      toggle_r   <= 1'b0;
      spr_ptr_r  <= 8'h00;
      rbuf_r     <= 8'h00;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clearing_r <= 1'b0;
        end
      end
      if (acc) begin
        ctrl_r     <= ctrl_nxt;
        mask_r     <= mask_nxt;
        status_r   <= status_nxt;
        cur_addr_r <= cur_addr_nxt;
        tmp_addr_r <= tmp_addr_nxt;
        fine_x_r   <= fine_x_nxt;
        toggle_r   <= toggle_nxt;
        spr_ptr_r  <= spr_ptr_nxt;
        s1_v_r     <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        if (s1_kind_r == vppu_pkg::RD_BUFFER) begin
          rbuf_r <= vid_rd_a_r;
        end else if (s1_kind_r == vppu_pkg::RD_PALETTE) begin
          rbuf_r <= vid_rd_b_r;
        end
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r <= kind_nxt;
      s1_item_r <= s1_item_nxt;
    end
    if (s1_move) begin
      out_item_r <= s1_out;
    end
  end

endmodule

FILE: sim/tb_video_ppu_register_port_top.sv
`timescale 1ns / 100ps
// Testbench for the video processor register port: drives bus accesses, predicts each
// result from its own copy of the register and memory state, and checks every transfer.
// Depends on vppu_pkg and video_ppu_register_port_top.
module tb_video_ppu_register_port_top;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vppu_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vppu_pkg::out_t out_item;

  logic [7:0] vid_mem [0:16383];
  logic [7:0] spr_mem [0:255];
  logic [7:0] spr_ptr = '0;
  logic [7:0] ctrl_reg = '0;
  logic [7:0] mask_reg = '0;
  logic [7:0] vid_status = '0;
  logic [15:0] vid_addr = '0;
  logic [14:0] vid_temp = '0;
  logic [2:0] fine_x = '0;
  logic addr_toggle = 1'b0;
  logic [7:0] read_buf = '0;

  vppu_pkg::out_t port_results_due [$];
  int unsigned mismatches = 0;
  int unsigned accesses_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit idle_enable = 1'b1;

  video_ppu_register_port_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic logic [13:0] map_video_addr(input logic [15:0] a);
    logic [13:0] m;
    m = a[13:0];
    if (m >= 14'h3F00) begin
      m = m & ~14'h00E0;
      if (m[4] && m[1:0] == 2'b00) m[4] = 1'b0;
    end else if (m >= 14'h2000) begin
      m[12] = 1'b0;
    end
    return m;
  endfunction

  function automatic vppu_pkg::out_t predict_port_access(input vppu_pkg::in_t acc);
    vppu_pkg::out_t res;
    logic [14:0] t;
    logic [15:0] stride;
    logic [7:0] d;
    res = '0;
    t = vid_temp;
    d = acc.data_in;
    stride = ctrl_reg[2] ? 16'd32 : 16'd1;
    case (acc.op)
      vppu_pkg::OP_READ: begin
        case (acc.reg_index)
          vppu_pkg::REG_STATUS: begin
            res.read_data = vid_status;
            addr_toggle = 1'b0;
            vid_status[7] = 1'b0;
          end
          vppu_pkg::REG_OAM_DATA: res.read_data = spr_mem[spr_ptr];
          vppu_pkg::REG_DATA: begin
            if (vid_addr[13:0] <= 14'h3EFF) begin
              res.read_data = read_buf;
              read_buf = vid_mem[map_video_addr(vid_addr)];
            end else begin
              read_buf = vid_mem[map_video_addr(vid_addr & ~16'h1000)];
              res.read_data = vid_mem[map_video_addr(vid_addr)];
            end
            vid_addr = vid_addr + stride;
          end
          default: ;
        endcase
      end
      vppu_pkg::OP_WRITE: begin
        case (acc.reg_index)
          vppu_pkg::REG_CTRL: begin
            t[11:10] = d[1:0];
            ctrl_reg = d;
          end
          vppu_pkg::REG_MASK: mask_reg = d;
          vppu_pkg::REG_OAM_ADDR: spr_ptr = d;
          vppu_pkg::REG_OAM_DATA: begin
            spr_mem[spr_ptr] = d;
            spr_ptr = spr_ptr + 8'd1;
          end
          vppu_pkg::REG_SCROLL: begin
            if (!addr_toggle) begin
              fine_x = d[2:0];
              t[4:0] = d[7:3];
            end else begin
              t[9:5] = d[7:3];
              t[14:12] = d[2:0];
            end
            addr_toggle = ~addr_toggle;
          end
          vppu_pkg::REG_ADDR: begin
            if (!addr_toggle) begin
              vid_addr = {d, 8'h00};
              t = {1'b0, d[5:0], t[7:0]};
            end else begin
              t[7:0] = d;
              vid_addr = {1'b0, t};
            end
            addr_toggle = ~addr_toggle;
          end
          vppu_pkg::REG_DATA: begin
            vid_mem[map_video_addr(vid_addr)] = d;
            vid_addr = vid_addr + stride;
          end
          default: ;
        endcase
        vid_temp = t;
      end
      vppu_pkg::OP_STATUS: vid_status = d;
      default: ;
    endcase
    res.vram_address = vid_addr;
    res.temp_address = vid_temp;
    res.fine_x_scroll = fine_x;
    res.control_byte = ctrl_reg;
    res.mask_byte = mask_reg;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin
    vppu_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) port_results_due.push_back(predict_port_access(in_item));
      if (out_valid && !out_stall) begin
        if (port_results_due.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(out_item.read_data), 0);
        end else begin
          want = port_results_due.pop_front();
          if (out_item.read_data !== want.read_data)
            report_mismatch("read_data", 32'(out_item.read_data),
                            32'(want.read_data));
          if (out_item.vram_address !== want.vram_address)
            report_mismatch("vram_address", 32'(out_item.vram_address),
                            32'(want.vram_address));
          if (out_item.temp_address !== want.temp_address)
            report_mismatch("temp_address", 32'(out_item.temp_address),
                            32'(want.temp_address));
          if (out_item.fine_x_scroll !== want.fine_x_scroll)
            report_mismatch("fine_x_scroll", 32'(out_item.fine_x_scroll),
                            32'(want.fine_x_scroll));
          if (out_item.control_byte !== want.control_byte)
            report_mismatch("control_byte", 32'(out_item.control_byte),
                            32'(want.control_byte));
          if (out_item.mask_byte !== want.mask_byte)
            report_mismatch("mask_byte", 32'(out_item.mask_byte),
                            32'(want.mask_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_stall_gen
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_access(input logic [1:0] op, input logic [2:0] idx,
                             input logic [7:0] data);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{op: op, reg_index: idx, data_in: data};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accesses_sent++;
  endtask

  task automatic wait_for_results;
    while (port_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_burst;
    logic [7:0] hi;
    int unsigned len;
    case ($urandom_range(0, 10))
      0, 1, 2: begin
        if ($urandom_range(0, 1))
          send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'($urandom));
        case ($urandom_range(0, 3))
          0: hi = 8'h3F;
          1: hi = 8'($urandom_range(8'h20, 8'h3E));
          2: hi = 8'($urandom_range(0, 8'h1F));
          default: hi = 8'($urandom);
        endcase
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, hi);
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'($urandom));
        len = $urandom_range(1, 8);
        repeat (len)
          send_access($urandom_range(0, 1) ? vppu_pkg::OP_READ : vppu_pkg::OP_WRITE,
                      vppu_pkg::REG_DATA, 8'($urandom));
      end
      3: begin
        if ($urandom_range(0, 1))
          send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'($urandom));
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_SCROLL, 8'($urandom));
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_SCROLL, 8'($urandom));
      end
      4: begin
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_OAM_ADDR, 8'($urandom));
        len = $urandom_range(1, 6);
        repeat (len)
          send_access($urandom_range(0, 1) ? vppu_pkg::OP_READ : vppu_pkg::OP_WRITE,
                      vppu_pkg::REG_OAM_DATA, 8'($urandom));
      end
      5: begin
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_CTRL, 8'($urandom));
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_MASK, 8'($urandom));
      end
      6: begin
        send_access(vppu_pkg::OP_STATUS, 3'($urandom), 8'($urandom));
        send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'($urandom));
        if ($urandom_range(0, 1))
          send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'($urandom));
      end
      7: begin
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_CTRL, 8'($urandom) | 8'h04);
        send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'($urandom));
        send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR,
                    8'($urandom_range(8'hF0, 8'hFF)));
        repeat (10)
          send_access($urandom_range(0, 1) ? vppu_pkg::OP_READ : vppu_pkg::OP_WRITE,
                      vppu_pkg::REG_DATA, 8'($urandom));
      end
      default: begin
        len = $urandom_range(1, 4);
        repeat (len) send_access(2'($urandom), 3'($urandom), 8'($urandom));
      end
    endcase
  endtask

  task automatic test_directed;
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_CTRL, 8'hFF);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_CTRL, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_MASK, 8'hFF);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_STATUS, 8'hAA);
    send_access(vppu_pkg::OP_STATUS, vppu_pkg::REG_CTRL, 8'hFF);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_STATUS, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_OAM_ADDR, 8'hFF);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_OAM_DATA, 8'h5A);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_OAM_DATA, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_SCROLL, 8'hFF);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_SCROLL, 8'hFF);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h3F);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_DATA, 8'h21);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h3F);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h10);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_DATA, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_DATA, 8'hC3);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h00);
    send_access(vppu_pkg::OP_WRITE, vppu_pkg::REG_ADDR, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_DATA, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_DATA, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_CTRL, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_MASK, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_OAM_ADDR, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_SCROLL, 8'h00);
    send_access(vppu_pkg::OP_READ, vppu_pkg::REG_ADDR, 8'h00);
    send_access(OP_NONE, vppu_pkg::REG_DATA, 8'hFF);
  endtask

  task automatic test_random_sequences;
    int unsigned stop_at;
    stop_at = accesses_sent + 700;
    while (accesses_sent < stop_at) begin
      idle_enable = ($urandom_range(0, 7) != 0);
      random_burst();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_backpressure;
    int unsigned stop_at;
    idle_enable = 1'b0;
    hold_cycles = 300;
    stop_at = accesses_sent + 60;
    while (accesses_sent < stop_at) random_burst();
    in_valid <= 1'b0;
    wait_for_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_streaming;
    int unsigned stop_at;
    idle_enable = 1'b0;
    stop_at = accesses_sent + 100;
    while (accesses_sent < stop_at) random_burst();
  endtask

  initial begin
    foreach (vid_mem[i]) vid_mem[i] = '0;
    foreach (spr_mem[i]) spr_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_sequences();
    test_backpressure();
    test_streaming();
    in_valid <= 1'b0;
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/vppu_pkg.sv
hdl/video_ppu_register_port_top.sv
sim/tb_video_ppu_register_port_top.sv
